@@ rtl/bf3_pkg.sv @@
// Shared types and constants for the 3x3 box filter with border copy.
// Used by the core, front and back modules; no dependencies of its own.
package bf3_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 8;
  localparam int ROW_LIMIT      = 1024;
  localparam int ROW_W          = 10;
  localparam int COORD_W        = 10;
  localparam int CFG_DATA_W     = 11;
  localparam int CFG_IDX_W      = 1;
  localparam int QUEUE_DEPTH    = 4;
  localparam int DIV_CONST      = 9;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // which results an item causes, and how the first one is formed
  typedef struct packed {
    logic mean;   // first result is the 3x3 mean, else a copy
    logic e1;     // result (r-1, c-1)
    logic e2;     // result (r-1, c), right border
    logic e3;     // result (r, c), bottom border
    logic eof;    // c is the last column
  } bf3_flags_t;

endpackage

@@ rtl/box_filter_3x3_border_copy_core.sv @@
// 3x3 box filter with border copy. One item per cycle sustained while results
// keep pace; an item causing k results holds the back half until all k have
// been emitted. Reset clears counters, window, queue and pipeline valids, sets
// the height to 1024 and the width to MAX_WIDTH capped at 1024; line stores
// are not cleared and hold nothing until written.
module box_filter_3x3_border_copy_core #(
  parameter int MAX_WIDTH  = bf3_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = bf3_pkg::PIXEL_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [bf3_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [bf3_pkg::CFG_DATA_W-1:0]           cfg_data,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // pixel_in
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]          s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // pixel_out, out_row, out_col
  output logic [((PIXEL_BITS+20+7)/8)*8-1:0]       m_axis_tdata,
  // last_of_run
  output logic                                     m_axis_tlast,
  // end_of_frame
  output logic                                     m_axis_tuser
);

  import bf3_pkg::*;

  localparam int SUM_W   = PIXEL_BITS + 4;
  localparam int QW      = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_W   = ((PIXEL_BITS + 20 + 7) / 8) * 8;
  localparam int ENTRY_W = $bits(bf3_flags_t) + SUM_W + 3 * PIXEL_BITS + 2 * COORD_W;

  logic                  q_push;
  logic                  q_pop;
  logic                  q_not_empty;
  logic [QW-1:0]         q_count;
  logic [ENTRY_W-1:0]    q_push_data;
  logic [ENTRY_W-1:0]    q_pop_data;

  bf3_flags_t            f_flags;
  logic [SUM_W-1:0]      f_sum;
  logic [PIXEL_BITS-1:0] f_v1;
  logic [PIXEL_BITS-1:0] f_a;
  logic [PIXEL_BITS-1:0] f_p;
  logic [COORD_W-1:0]    f_row;
  logic [COORD_W-1:0]    f_col;

  bf3_flags_t            k_flags;
  logic [SUM_W-1:0]      k_sum;
  logic [PIXEL_BITS-1:0] k_v1;
  logic [PIXEL_BITS-1:0] k_a;
  logic [PIXEL_BITS-1:0] k_p;
  logic [COORD_W-1:0]    k_row;
  logic [COORD_W-1:0]    k_col;

  logic [PIXEL_BITS-1:0] o_pix;
  logic [COORD_W-1:0]    o_row;
  logic [COORD_W-1:0]    o_col;

  assign cfg_ready = 1'b1;

  bf3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS),
    .SUM_W      (SUM_W),
    .QW         (QW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_pixel   (s_axis_tdata[PIXEL_BITS-1:0]),
    .in_ready   (s_axis_tready),
    .q_count    (q_count),
    .push       (q_push),
    .push_flags (f_flags),
    .push_sum   (f_sum),
    .push_v1    (f_v1),
    .push_a     (f_a),
    .push_p     (f_p),
    .push_row   (f_row),
    .push_col   (f_col)
  );

  assign q_push_data = {f_flags, f_sum, f_v1, f_a, f_p, f_row, f_col};

  bf3_queue #(
    .DATA_W (ENTRY_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  assign {k_flags, k_sum, k_v1, k_a, k_p, k_row, k_col} = q_pop_data;

  bf3_back #(
    .PIXEL_BITS (PIXEL_BITS),
    .SUM_W      (SUM_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_not_empty),
    .q_pop     (q_pop),
    .q_flags   (k_flags),
    .q_sum     (k_sum),
    .q_v1      (k_v1),
    .q_a       (k_a),
    .q_p       (k_p),
    .q_row     (k_row),
    .q_col     (k_col),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_pixel (o_pix),
    .out_row   (o_row),
    .out_col   (o_col),
    .out_last  (m_axis_tlast),
    .out_eof   (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_W'({o_col, o_row, o_pix});

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_count < QW'(QUEUE_DEPTH)))
    else $error("push into full queue");

  a_eof_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("end of frame not on last result of its item");
`endif

endmodule

@@ rtl/bf3_queue.sv @@
// Short FIFO between the front and back halves of the box filter.
// Depends on nothing; width and depth come from the instantiating level.
module bf3_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [DATA_W-1:0]          push_data,
  input  logic                       pop,
  output logic [DATA_W-1:0]          pop_data,
  output logic                       not_empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] store [DEPTH];
  logic [AW-1:0]     head;
  logic [AW-1:0]     tail;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      store[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= ptr_inc(tail);
      end
      if (pop) begin
        head <= ptr_inc(head);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign pop_data  = store[head];
  assign not_empty = (count != '0);

endmodule

@@ rtl/bf3_front.sv @@
// Front half: configuration, position counters, line stores, 3x3 window
// and classification of each item. Depends on bf3_pkg.
module bf3_front #(
  parameter int MAX_WIDTH  = bf3_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = bf3_pkg::PIXEL_BITS_DEF,
  parameter int SUM_W      = PIXEL_BITS + 4,
  parameter int QW         = 3
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [bf3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bf3_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic [PIXEL_BITS-1:0]           in_pixel,
  output logic                            in_ready,
  input  logic [QW-1:0]                   q_count,
  output logic                            push,
  output bf3_pkg::bf3_flags_t             push_flags,
  output logic [SUM_W-1:0]                push_sum,
  output logic [PIXEL_BITS-1:0]           push_v1,
  output logic [PIXEL_BITS-1:0]           push_a,
  output logic [PIXEL_BITS-1:0]           push_p,
  output logic [bf3_pkg::COORD_W-1:0]     push_row,
  output logic [bf3_pkg::COORD_W-1:0]     push_col
);

  import bf3_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int W_RST = ((MAX_WIDTH < ROW_LIMIT) ? MAX_WIDTH : ROW_LIMIT) - 1;

  logic [CW-1:0]    w_last;
  logic [ROW_W-1:0] h_last;
  logic [CW-1:0]    w_cfg_last;
  logic [ROW_W-1:0] h_cfg_last;

  logic [CW-1:0]    col_count;
  logic [ROW_W-1:0] row_count;
  logic [CW-1:0]    c_eff;
  logic [ROW_W-1:0] r_eff;
  logic             accept;
  bf3_flags_t       flags_next;

  logic [PIXEL_BITS-1:0] mem_a [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] mem_b [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] a_q;
  logic [PIXEL_BITS-1:0] b_q;
  logic                  fwd_q;
  logic [PIXEL_BITS-1:0] fwd_data;
  logic [PIXEL_BITS-1:0] b_val;

  logic                  s1_valid;
  bf3_flags_t            s1_flags;
  logic [PIXEL_BITS-1:0] s1_pix;
  logic [ROW_W-1:0]      s1_row;
  logic [CW-1:0]         s1_col;

  logic [PIXEL_BITS-1:0] win [3][3];

  // register writes, clamped to the supported range
  always_comb begin
    if (cfg_data == '0) begin
      w_cfg_last = '0;
    end else if (32'(cfg_data) > MAX_WIDTH) begin
      w_cfg_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_cfg_last = CW'(cfg_data - CFG_DATA_W'(1));
    end
    if (cfg_data == '0) begin
      h_cfg_last = '0;
    end else if (32'(cfg_data) > ROW_LIMIT) begin
      h_cfg_last = ROW_W'(ROW_LIMIT - 1);
    end else begin
      h_cfg_last = ROW_W'(cfg_data - CFG_DATA_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last <= CW'(W_RST);
      h_last <= ROW_W'(ROW_LIMIT - 1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  w_last <= w_cfg_last;
        REG_IMAGE_HEIGHT: h_last <= h_cfg_last;
      endcase
    end
  end

  // room for the item in stage 1 and for the one already there
  assign in_ready = (({1'b0, q_count} + {{QW{1'b0}}, s1_valid}) < (QW+1)'(QUEUE_DEPTH));
  assign accept   = in_valid && in_ready;

  assign c_eff = (col_count > w_last) ? '0 : col_count;
  assign r_eff = (row_count > h_last) ? '0 : row_count;

  always_comb begin
    flags_next.e1   = (r_eff != '0) && (c_eff != '0);
    flags_next.mean = (r_eff > ROW_W'(1)) && (c_eff > CW'(1));
    flags_next.e2   = (r_eff != '0) && (c_eff == w_last);
    flags_next.e3   = (r_eff == h_last);
    flags_next.eof  = (c_eff == w_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (c_eff >= w_last) begin
        col_count <= '0;
        row_count <= (r_eff >= h_last) ? '0 : r_eff + ROW_W'(1);
      end else begin
        col_count <= c_eff + CW'(1);
      end
    end
  end

  // line stores: row r-1 in mem_a, row r-2 in mem_b
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_a[c_eff] <= in_pixel;
      a_q          <= mem_a[c_eff];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_q <= mem_b[c_eff];
    end
    if (s1_valid) begin
      mem_b[s1_col] <= a_q;
    end
  end

  // same column written back-to-back (one-column image)
  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_q    <= s1_valid && (s1_col == c_eff);
      fwd_data <= a_q;
    end
  end

  assign b_val = fwd_q ? fwd_data : b_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags <= flags_next;
      s1_pix   <= in_pixel;
      s1_row   <= r_eff;
      s1_col   <= c_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (s1_valid) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= b_val;
      win[1][2] <= a_q;
      win[2][2] <= s1_pix;
    end
  end

  assign push_sum = SUM_W'(win[0][1]) + SUM_W'(win[0][2]) + SUM_W'(b_val)
                  + SUM_W'(win[1][1]) + SUM_W'(win[1][2]) + SUM_W'(a_q)
                  + SUM_W'(win[2][1]) + SUM_W'(win[2][2]) + SUM_W'(s1_pix);

  assign push       = s1_valid && (s1_flags.e1 || s1_flags.e2 || s1_flags.e3);
  assign push_flags = s1_flags;
  assign push_v1    = win[1][2];
  assign push_a     = a_q;
  assign push_p     = s1_pix;
  assign push_row   = COORD_W'(s1_row);
  assign push_col   = COORD_W'(s1_col);

endmodule

@@ rtl/bf3_back.sv @@
// Back half: divide-by-nine by reciprocal, then one result per cycle, while
// the output is taken, into the output register. Depends on bf3_pkg.
module bf3_back #(
  parameter int PIXEL_BITS = bf3_pkg::PIXEL_BITS_DEF,
  parameter int SUM_W      = PIXEL_BITS + 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  bf3_pkg::bf3_flags_t         q_flags,
  input  logic [SUM_W-1:0]            q_sum,
  input  logic [PIXEL_BITS-1:0]       q_v1,
  input  logic [PIXEL_BITS-1:0]       q_a,
  input  logic [PIXEL_BITS-1:0]       q_p,
  input  logic [bf3_pkg::COORD_W-1:0] q_row,
  input  logic [bf3_pkg::COORD_W-1:0] q_col,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [PIXEL_BITS-1:0]       out_pixel,
  output logic [bf3_pkg::COORD_W-1:0] out_row,
  output logic [bf3_pkg::COORD_W-1:0] out_col,
  output logic                        out_last,
  output logic                        out_eof
);

  import bf3_pkg::*;

  localparam int SH     = SUM_W + 3;
  localparam int PROD_W = 2 * SUM_W;
  localparam int RECIP  = (2 ** SH) / DIV_CONST;

  logic                  b1_valid;
  bf3_flags_t            b1_flags;
  logic [PROD_W-1:0]     b1_prod;
  logic [SUM_W-1:0]      b1_sum;
  logic [PIXEL_BITS-1:0] b1_v1;
  logic [PIXEL_BITS-1:0] b1_a;
  logic [PIXEL_BITS-1:0] b1_p;
  logic [COORD_W-1:0]    b1_row;
  logic [COORD_W-1:0]    b1_col;
  logic                  b1_move;

  logic [SUM_W-1:0]      q_est;
  logic [SUM_W-1:0]      nine_q;
  logic [SUM_W-1:0]      rem;
  logic [SUM_W-1:0]      q_fix;

  logic                  job_valid;
  logic [2:0]            pend;
  logic [2:0]            pend_rest;
  logic [PIXEL_BITS-1:0] j_v1;
  logic [PIXEL_BITS-1:0] j_a;
  logic [PIXEL_BITS-1:0] j_p;
  logic [COORD_W-1:0]    j_row;
  logic [COORD_W-1:0]    j_col;
  logic                  j_eof;
  logic                  job_free;
  logic                  emit_fire;
  logic                  emit_last;

  logic [PIXEL_BITS-1:0] e_pix;
  logic [COORD_W-1:0]    e_row;
  logic [COORD_W-1:0]    e_col;
  logic                  e_eof;

  assign emit_fire = job_valid && (!out_valid || out_ready);
  assign pend_rest = pend & (pend - 3'd1);
  assign emit_last = (pend_rest == 3'd0);
  assign job_free  = !job_valid || (emit_fire && emit_last);
  assign b1_move   = b1_valid && job_free;
  assign q_pop     = q_valid && (!b1_valid || job_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (q_pop) begin
      b1_valid <= 1'b1;
    end else if (b1_move) begin
      b1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_flags <= q_flags;
      b1_prod  <= PROD_W'(q_sum) * PROD_W'(RECIP);
      b1_sum   <= q_sum;
      b1_v1    <= q_v1;
      b1_a     <= q_a;
      b1_p     <= q_p;
      b1_row   <= q_row;
      b1_col   <= q_col;
    end
  end

  // estimate is exact or one short
  always_comb begin
    q_est  = SUM_W'(b1_prod >> SH);
    nine_q = {q_est[SUM_W-4:0], 3'b000} + q_est;
    rem    = b1_sum - nine_q;
    q_fix  = (rem >= SUM_W'(DIV_CONST)) ? q_est + SUM_W'(1) : q_est;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      pend      <= '0;
    end else if (b1_move) begin
      job_valid <= 1'b1;
      pend      <= {b1_flags.e3, b1_flags.e2, b1_flags.e1};
    end else if (emit_fire) begin
      job_valid <= !emit_last;
      pend      <= pend_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_move) begin
      j_v1  <= b1_flags.mean ? PIXEL_BITS'(q_fix) : b1_v1;
      j_a   <= b1_a;
      j_p   <= b1_p;
      j_row <= b1_row;
      j_col <= b1_col;
      j_eof <= b1_flags.eof;
    end
  end

  always_comb begin
    if (pend[0]) begin
      e_pix = j_v1;
      e_row = j_row - COORD_W'(1);
      e_col = j_col - COORD_W'(1);
      e_eof = 1'b0;
    end else if (pend[1]) begin
      e_pix = j_a;
      e_row = j_row - COORD_W'(1);
      e_col = j_col;
      e_eof = 1'b0;
    end else begin
      e_pix = j_p;
      e_row = j_row;
      e_col = j_col;
      e_eof = j_eof;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_pixel <= e_pix;
      out_row   <= e_row;
      out_col   <= e_col;
      out_last  <= emit_last;
      out_eof   <= e_eof;
    end
  end

endmodule
